FILE: hdl/one_euro_adaptive_filter_assert.svh
// Assertion macros for the one-euro filter block.
// Used by one_euro_adaptive_filter.sv; expects clk and rst_n in scope.
`ifndef ONE_EURO_ADAPTIVE_FILTER_ASSERT_SVH
`define ONE_EURO_ADAPTIVE_FILTER_ASSERT_SVH
`ifndef SYNTH
`define OEAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OEAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OEAF_ASSERT_IMP(lbl, ante, cons)
`define OEAF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/oeaf_pkg.sv
// Shared constants and types of the one-euro filter block.
// No dependencies.
package oeaf_pkg;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CUT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DER_CUT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_OUT = 3'd4;
  localparam logic [31:0] RST_PERIOD   = 32'd4294967;
  localparam logic [31:0] RST_MIN_CUT  = 32'd65536;
  localparam logic [31:0] RST_GAIN     = 32'd0;
  localparam logic [31:0] RST_DER_CUT  = 32'd65536;
  localparam logic [31:0] RST_INIT_OUT = 32'd0;
  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;   // 2*pi in Q.24
  localparam logic [35:0] FCT_MAX    = 36'hFFFFFFFFF;
  localparam logic [32:0] ONE_Q32    = 33'h100000000;
  localparam int MUL_DIG = 17;                          // multiplier digit width
  localparam int MUL_BW  = 2 * MUL_DIG;                 // second operand width
  localparam int DIV_DW  = 48;                          // divisor / remainder width

  typedef enum logic [3:0] {
    S_IDLE, S_DER_DIV, S_AL_START, S_AL_MUL1, S_AL_MUL2, S_AL_DIV,
    S_BL_START, S_BL_MUL, S_CUT_MUL, S_OUT
  } state_t;
endpackage

FILE: hdl/oeaf_mul.sv
// Unsigned multiplier, one 17-bit digit of b per cycle.
// Depends on oeaf_pkg.
module oeaf_mul #(
  parameter int AW = 36
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [AW-1:0]                 a,
  input  logic [oeaf_pkg::MUL_BW-1:0]   b,
  output logic                          done,
  output logic [AW+oeaf_pkg::MUL_BW-1:0] prod
);
  localparam int DG = oeaf_pkg::MUL_DIG;
  localparam int PW = AW + oeaf_pkg::MUL_BW;

  logic [AW-1:0]               a_r;
  logic [oeaf_pkg::MUL_BW-1:0] b_r;
  logic                        busy_r, hi_r, done_r;
  logic [PW-1:0]               acc_r;
  logic [DG-1:0]               digit;
  logic [AW+DG-1:0]            pp;
  logic [PW-1:0]               pp_ext;

  always_comb begin
    digit  = hi_r ? b_r[2*DG-1:DG] : b_r[DG-1:0];
    pp     = (AW+DG)'(a_r) * (AW+DG)'(digit);
    pp_ext = hi_r ? (PW'(pp) << DG) : PW'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hi_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        busy_r <= 1'b1;
        hi_r   <= 1'b0;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_ext;
        hi_r  <= 1'b1;
        if (hi_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

FILE: hdl/oeaf_div.sv
// Restoring divider, one quotient bit per cycle, preloadable remainder.
// Uses no package; widths come from parameters.
module oeaf_div #(
  parameter int QW = 65,
  parameter int RW = 48,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] rem_init,
  input  logic [QW-1:0] dvd,
  input  logic [RW-1:0] dvs,
  input  logic [CW-1:0] nbits,
  output logic          done,
  output logic [QW-1:0] quot
);
  logic [RW-1:0] rem_r, dvs_r;
  logic [QW-1:0] dvd_r, q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [RW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_r, dvd_r[QW-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= rem_init;
        dvd_r  <= dvd;
        dvs_r  <= dvs;
        q_r    <= '0;
        cnt_r  <= nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
        dvd_r <= dvd_r << 1;
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: hdl/one_euro_adaptive_filter.sv
// One-euro adaptive smoothing filter, top level with sequencer.
// Depends on oeaf_pkg, oeaf_mul, oeaf_div, one_euro_adaptive_filter_assert.svh.
//
// Usage:
//  - in_* carries one signed Q16.16 sample per request; out_* returns the
//    smoothed value and the smoothed derivative (speed) for that sample.
//  - cfg_* writes one of five registers (period, min cutoff, speed gain,
//    derivative cutoff, initial output); any valid write reloads the filter
//    state. Indexes above four are ignored. cfg_ready is always high.
//  - The shared restoring divider runs SAMPLE_BITS+33 steps for the raw
//    derivative and 32 steps for each of the two alpha terms; the shared
//    multiplier runs seven times. A zero cutoff skips its two alpha
//    multiplies and its alpha division.
//  - in_tready is high only while the sequencer is idle; one item at a time.
//  - The result sits in an output register; a new sample may be taken while
//    it waits. If the next result finishes before the receiver takes the old
//    one, the sequencer holds until out_tready.
//  - Reset loads the register defaults, clears the speed state and sets the
//    smoothed state to the saturated initial output.
`include "one_euro_adaptive_filter_assert.svh"
module one_euro_adaptive_filter #(
  parameter int SAMPLE_BITS = oeaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,   // sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata, // smoothed, speed
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oeaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);
  localparam int SB     = SAMPLE_BITS;
  localparam int OUT_TW = ((2*SB+7)/8)*8;
  localparam int AW     = (SB + 1 > 36) ? SB + 1 : 36;
  localparam int MBW    = oeaf_pkg::MUL_BW;
  localparam int PW     = AW + MBW;
  localparam int QW     = SB + 33;
  localparam int RW     = oeaf_pkg::DIV_DW;
  localparam int CW     = $clog2(QW + 1);
  localparam logic signed [63:0] POS_LIM = (64'sd1 <<< (SB-1)) - 64'sd1;
  localparam logic signed [63:0] NEG_LIM = -(64'sd1 <<< (SB-1));

  // configuration
  logic [31:0] period_r, min_cut_r, gain_r, der_cut_r, init_out_r;
  // filter state and working registers
  oeaf_pkg::state_t state_r, state_nxt;
  logic                 phase_r, phase_nxt;     // 0: derivative filter, 1: main
  logic signed [SB-1:0] s_r, s_nxt;
  logic signed [SB-1:0] last_sm_r, last_spd_r;
  logic signed [SB-1:0] target_r, target_nxt, prev_r, prev_nxt;
  logic signed [SB-1:0] spd_r, spd_nxt, sm_r, sm_nxt;
  logic [31:0]          fc_r, fc_nxt;
  logic [32:0]          alpha_r, alpha_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r;
  logic [OUT_TW-1:0]    out_data_r;
  logic                 out_load;

  // shared units
  logic          mul_start, mul_done;
  logic [AW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_done;
  logic [RW-1:0] div_rem, div_dvs;
  logic [QW-1:0] div_dvd, div_quot;
  logic [CW-1:0] div_nbits;

  // datapath temporaries
  logic [31:0]          period_eff;
  logic signed [SB:0]   dsum;
  logic [SB:0]          dmag;
  logic signed [SB-1:0] raw, res;
  logic [SB-1:0]        st, amag;
  logic [PW-25:0]       qfull;
  logic [35:0]          q36;
  logic [46:0]          x32;
  logic [PW-16:0]       csum;
  logic [31:0]          io_src;
  logic signed [63:0]   io64;
  logic signed [SB-1:0] reload_val;
  logic                 cfg_hit;

  oeaf_mul #(.AW(AW)) u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  oeaf_div #(.QW(QW), .RW(RW), .CW(CW)) u_div (
    .clk, .rst_n, .start(div_start), .rem_init(div_rem), .dvd(div_dvd),
    .dvs(div_dvs), .nbits(div_nbits), .done(div_done), .quot(div_quot)
  );

  assign in_tready  = (state_r == oeaf_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_hit    = cfg_valid && (cfg_index <= oeaf_pkg::CFG_INIT_OUT);

  // reload value: the initial output being written wins over the stored one
  always_comb begin
    io_src = (cfg_valid && cfg_index == oeaf_pkg::CFG_INIT_OUT) ? cfg_data : init_out_r;
    io64   = {{32{io_src[31]}}, io_src};
    if (io64 > POS_LIM)      reload_val = POS_LIM[SB-1:0];
    else if (io64 < NEG_LIM) reload_val = NEG_LIM[SB-1:0];
    else                     reload_val = io64[SB-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    s_nxt      = s_r;
    target_nxt = target_r;
    prev_nxt   = prev_r;
    spd_nxt    = spd_r;
    sm_nxt     = sm_r;
    fc_nxt     = fc_r;
    alpha_nxt  = alpha_r;
    neg_nxt    = neg_r;
    out_load   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_rem    = '0;
    div_dvd    = '0;
    div_dvs    = '0;
    div_nbits  = '0;

    period_eff = (period_r == 32'd0) ? 32'd1 : period_r;   // zero period acts as 1
    dsum  = '0;
    dmag  = '0;
    raw   = '0;
    res   = '0;
    st    = mul_prod[32 +: SB];
    amag  = '0;
    qfull = mul_prod[PW-1:24];
    q36   = (|qfull[PW-25:36]) ? oeaf_pkg::FCT_MAX : qfull[35:0];
    x32   = mul_prod[62:16];
    csum  = (PW-15)'(mul_prod[PW-1:16]) + (PW-15)'(min_cut_r);

    case (state_r)
      oeaf_pkg::S_IDLE: begin
        dsum = $signed({in_tdata[SB-1], in_tdata[SB-1:0]}) - $signed({last_sm_r[SB-1], last_sm_r});
        dmag = dsum[SB] ? (SB+1)'(-dsum) : dsum;
        if (in_tvalid) begin
          s_nxt     = in_tdata[SB-1:0];
          neg_nxt   = dsum[SB];
          div_start = 1'b1;
          div_dvd   = {dmag, 32'd0};
          div_dvs   = RW'(period_eff);
          div_nbits = CW'(QW);
          state_nxt = oeaf_pkg::S_DER_DIV;
        end
      end
      oeaf_pkg::S_DER_DIV: begin
        if (div_done) begin
          // raw derivative, saturated to the sample range
          if (|div_quot[QW-1:SB-1]) raw = neg_r ? NEG_LIM[SB-1:0] : POS_LIM[SB-1:0];
          else raw = neg_r ? -$signed(div_quot[SB-1:0]) : $signed(div_quot[SB-1:0]);
          target_nxt = raw;
          prev_nxt   = last_spd_r;
          fc_nxt     = der_cut_r;
          phase_nxt  = 1'b0;
          state_nxt  = oeaf_pkg::S_AL_START;
        end
      end
      oeaf_pkg::S_AL_START: begin
        if (fc_r == 32'd0) begin
          alpha_nxt = oeaf_pkg::ONE_Q32;
          state_nxt = oeaf_pkg::S_BL_START;
        end else begin
          mul_start = 1'b1;
          mul_a     = AW'(fc_r);
          mul_b     = MBW'(period_eff);
          state_nxt = oeaf_pkg::S_AL_MUL1;
        end
      end
      oeaf_pkg::S_AL_MUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = AW'(q36);
          mul_b     = MBW'(oeaf_pkg::TWO_PI_Q24);
          state_nxt = oeaf_pkg::S_AL_MUL2;
        end
      end
      oeaf_pkg::S_AL_MUL2: begin
        if (mul_done) begin
          // alpha = wT / (1 + wT), 32 fraction bits
          div_start = 1'b1;
          div_rem   = RW'(x32);
          div_dvs   = RW'(oeaf_pkg::ONE_Q32) + RW'(x32);
          div_nbits = CW'(32);
          state_nxt = oeaf_pkg::S_AL_DIV;
        end
      end
      oeaf_pkg::S_AL_DIV: begin
        if (div_done) begin
          alpha_nxt = {1'b0, div_quot[31:0]};
          state_nxt = oeaf_pkg::S_BL_START;
        end
      end
      oeaf_pkg::S_BL_START: begin
        dsum      = $signed({target_r[SB-1], target_r}) - $signed({prev_r[SB-1], prev_r});
        dmag      = dsum[SB] ? (SB+1)'(-dsum) : dsum;
        neg_nxt   = dsum[SB];
        mul_start = 1'b1;
        mul_a     = AW'(dmag);
        mul_b     = MBW'(alpha_r);
        state_nxt = oeaf_pkg::S_BL_MUL;
      end
      oeaf_pkg::S_BL_MUL: begin
        if (mul_done) begin
          res = neg_r ? prev_r - $signed(st) : prev_r + $signed(st);
          if (!phase_r) begin
            spd_nxt   = res;
            amag      = res[SB-1] ? SB'(-res) : res;
            mul_start = 1'b1;
            mul_a     = AW'(amag);
            mul_b     = MBW'(gain_r);
            state_nxt = oeaf_pkg::S_CUT_MUL;
          end else begin
            sm_nxt    = res;
            state_nxt = oeaf_pkg::S_OUT;
          end
        end
      end
      oeaf_pkg::S_CUT_MUL: begin
        if (mul_done) begin
          // cutoff saturates at 32 bits
          fc_nxt     = (|csum[PW-16:32]) ? 32'hFFFFFFFF : csum[31:0];
          target_nxt = s_r;
          prev_nxt   = last_sm_r;
          phase_nxt  = 1'b1;
          state_nxt  = oeaf_pkg::S_AL_START;
        end
      end
      oeaf_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = oeaf_pkg::S_IDLE;
        end
      end
      default: state_nxt = oeaf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oeaf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      period_r    <= oeaf_pkg::RST_PERIOD;
      min_cut_r   <= oeaf_pkg::RST_MIN_CUT;
      gain_r      <= oeaf_pkg::RST_GAIN;
      der_cut_r   <= oeaf_pkg::RST_DER_CUT;
      init_out_r  <= oeaf_pkg::RST_INIT_OUT;
      // default initial output is zero, inside the range of every width
      last_sm_r   <= SB'($signed(oeaf_pkg::RST_INIT_OUT));
      last_spd_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (out_load) begin
        last_sm_r  <= sm_r;
        last_spd_r <= spd_r;
      end
      if (cfg_valid) begin
        case (cfg_index)
          oeaf_pkg::CFG_PERIOD:   period_r   <= cfg_data;
          oeaf_pkg::CFG_MIN_CUT:  min_cut_r  <= cfg_data;
          oeaf_pkg::CFG_GAIN:     gain_r     <= cfg_data;
          oeaf_pkg::CFG_DER_CUT:  der_cut_r  <= cfg_data;
          oeaf_pkg::CFG_INIT_OUT: init_out_r <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        last_sm_r  <= reload_val;
        last_spd_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    s_r      <= s_nxt;
    target_r <= target_nxt;
    prev_r   <= prev_nxt;
    spd_r    <= spd_nxt;
    sm_r     <= sm_nxt;
    fc_r     <= fc_nxt;
    alpha_r  <= alpha_nxt;
    neg_r    <= neg_nxt;
    if (out_load) out_data_r <= OUT_TW'({spd_r, sm_r});
  end

  `OEAF_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, state_r == oeaf_pkg::S_DER_DIV)
  `OEAF_ASSERT_IMP(a_one_unit, mul_done, !div_done)
  `OEAF_ASSERT_IMP(a_idle_quiet, state_r == oeaf_pkg::S_IDLE, !mul_done && !div_done)
  `OEAF_ASSERT_NXT(a_out_load, out_load, out_tvalid && state_r == oeaf_pkg::S_IDLE)
endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the one-euro adaptive filter: directed and random samples,
// several register settings and handshake idling. Depends on oeaf_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;
  localparam logic [63:0] TWO_PI = 64'd105414357;
  localparam logic [63:0] FCT_LIM = 64'hFFFFFFFFF;
  localparam int STALL_LIMIT = 20000;   // cycles without any transfer
  localparam int EXP_DEPTH = 64;        // expected results in flight, far above need
  // register index that no register answers to
  localparam logic [oeaf_pkg::CFG_IDX_BITS-1:0] CFG_NONE = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;            // sample
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;                // smoothed, speed
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [oeaf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  one_euro_adaptive_filter dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the registers and filter state
  logic [31:0] reg_period, reg_min_cut, reg_gain, reg_der_cut;
  logic signed [31:0] reg_init;
  logic signed [63:0] st_smoothed, st_speed;

  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] smoothed;
  } filt_result_t;
  filt_result_t exp_mem [EXP_DEPTH];
  int exp_wr = 0;            // results predicted so far
  int exp_rd = 0;            // results checked so far

  int errors = 0;
  int send_idle_pct = 0;     // percent of cycles the sender sits out
  int recv_stall_pct = 0;    // percent of cycles the receiver stalls
  bit hold_recv = 1'b0;      // long receiver hold-off
  int idle_cycles = 0;

  function automatic logic [63:0] eff_period();
    return (reg_period == 0) ? 64'd1 : {32'd0, reg_period};
  endfunction

  // alpha in Q.32 (value 2^32 means pass-through)
  function automatic logic [63:0] alpha_for(logic [63:0] fc);
    logic [63:0] q, x32, den, r, a;
    if (fc == 0) return 64'h1_0000_0000;
    q = (fc * eff_period()) >> 24;
    if (q > FCT_LIM) q = FCT_LIM;
    x32 = (q * TWO_PI) >> 16;
    den = 64'h1_0000_0000 + x32;
    r = x32;
    a = 0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      a = a << 1;
      if (r >= den) begin
        r = r - den;
        a[0] = 1'b1;
      end
    end
    return a;
  endfunction

  function automatic logic signed [63:0] blend_step(logic signed [63:0] prev,
      logic signed [63:0] target, logic [63:0] a);
    logic signed [63:0] d;
    logic [63:0] mag, st;
    d = target - prev;
    mag = d < 0 ? -d : d;
    st = (mag >> 32) * a + (((mag & 64'hFFFFFFFF) * a) >> 32);
    return d < 0 ? prev - $signed(st) : prev + $signed(st);
  endfunction

  function automatic logic signed [63:0] raw_rate(logic signed [63:0] diff);
    logic [63:0] mag, t, qh, r, q;
    mag = diff < 0 ? -diff : diff;
    t = eff_period();
    qh = mag / t;
    r = mag % t;
    if (qh > 0) return diff < 0 ? -64'sd2147483648 : 64'sd2147483647;
    q = (r << 32) / t;
    if (diff < 0) return q >= 64'd2147483648 ? -64'sd2147483648 : -$signed(q);
    return q >= 64'd2147483648 ? 64'sd2147483647 : $signed(q);
  endfunction

  task automatic predict_sample(logic [31:0] smp);
    logic signed [63:0] s, spd, sm;
    logic [63:0] amag, cut;
    filt_result_t res;
    s = $signed(smp);
    spd = blend_step(st_speed, raw_rate(s - st_smoothed), alpha_for(reg_der_cut));
    amag = spd < 0 ? -spd : spd;
    cut = reg_min_cut + (amag >> 16) * reg_gain + (((amag & 64'hFFFF) * reg_gain) >> 16);
    if (cut > 64'hFFFFFFFF) cut = 64'hFFFFFFFF;
    sm = blend_step(st_smoothed, s, alpha_for(cut));
    st_smoothed = sm;
    st_speed = spd;
    res.smoothed = sm[31:0];
    res.speed = spd[31:0];
    exp_mem[exp_wr % EXP_DEPTH] = res;
    exp_wr++;
  endtask

  function automatic void reload_state();
    st_smoothed = reg_init;
    st_speed = 0;
  endfunction

  // one request on the input channel
  task automatic send_sample(logic [31:0] smp);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
      @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(smp);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (300) @(posedge clk);   // quiet gap between phases
  endtask

  task automatic write_reg(logic [oeaf_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      oeaf_pkg::CFG_PERIOD:   reg_period = val;
      oeaf_pkg::CFG_MIN_CUT:  reg_min_cut = val;
      oeaf_pkg::CFG_GAIN:     reg_gain = val;
      oeaf_pkg::CFG_DER_CUT:  reg_der_cut = val;
      oeaf_pkg::CFG_INIT_OUT: reg_init = val;
      default: return;
    endcase
    reload_state();
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return $signed($urandom_range(131072, 0)) - 65536;
      2: return st_smoothed[31:0] + $urandom_range(2000, 0) - 1000;
      default: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] pts[$];
    pts = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1, 32'h10000,
            32'hFFFF0000, 32'h55555555, 32'hAAAAAAAA, 32'h0};
    foreach (pts[i]) send_sample(pts[i]);
    drain();
    // zero cutoffs pass the target through; zero period; huge gain
    write_reg(oeaf_pkg::CFG_MIN_CUT, 32'd0);
    write_reg(oeaf_pkg::CFG_DER_CUT, 32'd0);
    write_reg(oeaf_pkg::CFG_PERIOD, 32'd0);
    foreach (pts[i]) send_sample(pts[i]);
    drain();
    write_reg(oeaf_pkg::CFG_PERIOD, 32'hFFFFFFFF);
    write_reg(oeaf_pkg::CFG_GAIN, 32'hFFFFFFFF);
    write_reg(oeaf_pkg::CFG_MIN_CUT, 32'hFFFFFFFF);
    write_reg(oeaf_pkg::CFG_DER_CUT, 32'hFFFFFFFF);
    write_reg(oeaf_pkg::CFG_INIT_OUT, 32'h80000000);
    send_sample(32'h7FFFFFFF);
    send_sample(32'h0);
    drain();
    // out-of-range index must neither change nor reload anything
    write_reg(CFG_NONE, 32'h12345678);
    send_sample(32'h80000000);
    drain();
  endtask

  task automatic test_random(int count, int sp, int rp);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    repeat (count) send_sample(rand_sample());
    drain();
  endtask

  task automatic random_config();
    write_reg(oeaf_pkg::CFG_PERIOD,
              $urandom_range(1, 0) ? $urandom_range(100000000, 1) : $urandom());
    write_reg(oeaf_pkg::CFG_MIN_CUT, $urandom_range(2000000, 0));
    write_reg(oeaf_pkg::CFG_GAIN, $urandom_range(1, 0) ? $urandom_range(70000, 0) : $urandom());
    write_reg(oeaf_pkg::CFG_DER_CUT, $urandom_range(3000000, 0));
    write_reg(oeaf_pkg::CFG_INIT_OUT, $urandom());
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (12) send_sample(rand_sample());
    join
    drain();
  endtask

  initial begin
    reg_period = oeaf_pkg::RST_PERIOD;
    reg_min_cut = oeaf_pkg::RST_MIN_CUT;
    reg_gain = oeaf_pkg::RST_GAIN;
    reg_der_cut = oeaf_pkg::RST_DER_CUT;
    reg_init = oeaf_pkg::RST_INIT_OUT;
    reload_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    random_config();
    test_random(200, 0, 0);
    random_config();
    test_random(200, 53, 0);
    random_config();
    test_backpressure();
    test_random(200, 0, 53);
    write_reg(oeaf_pkg::CFG_PERIOD, oeaf_pkg::RST_PERIOD);
    write_reg(oeaf_pkg::CFG_MIN_CUT, 32'd65536);
    write_reg(oeaf_pkg::CFG_GAIN, 32'd300);
    write_reg(oeaf_pkg::CFG_DER_CUT, 32'd65536);
    write_reg(oeaf_pkg::CFG_INIT_OUT, 32'd0);
    test_random(200, 20, 20);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver side: random stall, checks each accepted result
  always @(posedge clk) begin
    filt_result_t got, want;
    out_tready <= !hold_recv &&
        !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (exp_wr == exp_rd) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.smoothed !== want.smoothed) begin
          $display("%0t smoothed exp %h got %h", $time, want.smoothed, got.smoothed);
          errors++;
        end
        if (got.speed !== want.speed) begin
          $display("%0t speed exp %h got %h", $time, want.speed, got.speed);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end
endmodule
